>>> hw/rtl/chtsb_pkg.sv
`default_nettype none
package chtsb_pkg;

  // default sizes of the table
  localparam int BUCKETS_DEF = 16;
  localparam int SLOTS_DEF   = 8;

  // fixed field widths
  localparam int KEY_W    = 31;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int BUCKET_W = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_DELETE = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [BUCKET_W-1:0] bucket_t;

  typedef struct packed {
    mode_e mode;
    key_t  key;
  } in_item_t;

  typedef struct packed {
    status_e status;
    bucket_t bucket;
  } out_item_t;

  // outcome of one row update
  typedef struct packed {
    logic    wr;
    status_e status;
  } row_res_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_UPDATE
  } state_e;

endpackage
`default_nettype wire

>>> hw/rtl/chtsb_hash.sv
`default_nettype none
module chtsb_hash #(
  parameter int BUCKETS = chtsb_pkg::BUCKETS_DEF,
  parameter int BW      = $clog2(BUCKETS)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire chtsb_pkg::key_t         key,
  output logic                         done,
  output logic [BW-1:0]                bucket
);

  // reciprocal of the bucket count, scaled by 2^32
  localparam logic [63:0] MAGIC_W = (64'd1 << 32) / BUCKETS;
  localparam logic [31:0] MAGIC   = MAGIC_W[31:0];
  localparam logic [BW:0] BKT_C   = (BW+1)'(BUCKETS);
  localparam int          PROD_W  = chtsb_pkg::KEY_W + 32;

  logic                           v1_r;
  logic                           v2_r;
  logic [chtsb_pkg::KEY_W+31:0]   prod_r;
  chtsb_pkg::key_t                key1_r;
  logic [chtsb_pkg::KEY_W-1:0]    quot;
  logic [chtsb_pkg::KEY_W-1:0]    qb;
  logic [BW:0]                    rem_r;
  logic [BW:0]                    rem_fix;

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
    end
  end

  // estimated quotient, at most one low
  assign quot = prod_r[chtsb_pkg::KEY_W+31:32];
  assign qb   = quot * {{(chtsb_pkg::KEY_W-BW-1){1'b0}}, BKT_C};

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= PROD_W'(key) * PROD_W'(MAGIC);
      key1_r <= key;
    end
    if (v1_r) begin
      rem_r <= (BW+1)'(key1_r - qb);
    end
  end

  // remainder is below twice the bucket count: one correction
  assign rem_fix = (rem_r >= BKT_C) ? (rem_r - BKT_C) : rem_r;
  assign bucket  = rem_fix[BW-1:0];
  assign done    = v2_r;

endmodule
`default_nettype wire

>>> hw/rtl/chtsb_row_upd.sv
`default_nettype none
module chtsb_row_upd #(
  parameter int SLOTS = chtsb_pkg::SLOTS_DEF,
  parameter int FW    = $clog2(SLOTS + 1)
) (
  input  wire chtsb_pkg::mode_e                          mode,
  input  wire chtsb_pkg::key_t                           key,
  input  wire logic [FW-1:0]                             fill,
  input  wire logic [SLOTS-1:0][chtsb_pkg::KEY_W-1:0]    slots,
  output logic [SLOTS-1:0][chtsb_pkg::KEY_W-1:0]         slots_nxt,
  output logic [FW-1:0]                                  fill_nxt,
  output chtsb_pkg::row_res_t                            res
);

  localparam logic [FW-1:0] FULL_C = FW'(SLOTS);

  logic [SLOTS-1:0]                          lt;
  logic [SLOTS-1:0]                          eq;
  logic [SLOTS-1:0][chtsb_pkg::KEY_W-1:0]    ins_row;
  logic [SLOTS-1:0][chtsb_pkg::KEY_W-1:0]    del_row;
  logic                                      found;
  logic                                      full;

  // per-slot compare; keys below the fill count are sorted, so lt is a prefix
  for (genvar i = 0; i < SLOTS; i++) begin : g_lane
    localparam logic [FW-1:0] IDX = FW'(i);
    logic live;
    assign live = (IDX < fill);
    assign lt[i] = live && (slots[i] < key);
    assign eq[i] = live && (slots[i] == key);

    // insert: keep the smaller keys, place the key, shift the rest up
    if (i == 0) begin : g_first
      assign ins_row[i] = lt[i] ? slots[i] : key;
    end else begin : g_rest
      assign ins_row[i] = lt[i] ? slots[i] : (lt[i-1] ? key : slots[i-1]);
    end

    // delete: equal keys are contiguous, first one sits where lt ends
    if (i == SLOTS - 1) begin : g_last
      assign del_row[i] = slots[i];
    end else begin : g_mid
      assign del_row[i] = lt[i] ? slots[i] : slots[i+1];
    end
  end

  assign found = |eq;
  assign full  = (fill >= FULL_C);

  always_comb begin
    slots_nxt  = slots;
    fill_nxt   = fill;
    res.wr     = 1'b0;
    res.status = chtsb_pkg::ST_NOT_FOUND;
    case (mode)
      chtsb_pkg::MODE_INSERT: begin
        if (full) begin
          res.status = chtsb_pkg::ST_FULL;
        end else begin
          slots_nxt  = ins_row;
          fill_nxt   = fill + FW'(1);
          res.wr     = 1'b1;
          res.status = chtsb_pkg::ST_OK;
        end
      end
      chtsb_pkg::MODE_SEARCH: begin
        if (found) begin
          res.status = chtsb_pkg::ST_OK;
        end
      end
      chtsb_pkg::MODE_DELETE: begin
        if (found) begin
          slots_nxt  = del_row;
          fill_nxt   = fill - FW'(1);
          res.wr     = 1'b1;
          res.status = chtsb_pkg::ST_OK;
        end
      end
      default: begin
        res.status = chtsb_pkg::ST_NOT_FOUND;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/chained_hash_table_sorted_buckets.sv
`default_nettype none
// channel  | ports                         | payload
// ---------+-------------------------------+----------------------------
// input    | in_valid, in_stall, in_data   | mode, key (in_item_t)
// result   | out_valid, out_stall, out_data| status, bucket (out_item_t)
//
// In a transaction two multiply stages form key mod BUCKETS, then the bucket
// row is read into a register, and then it is compared, shifted and written back.
// After reset a clearing pass zeroes the fill memory, one bucket per cycle, with
// in_stall high. Exactly one result per transaction.
// A finished result waits in the output register; the next transaction may be
// accepted meanwhile but its write-back waits until that register is free.
module chained_hash_table_sorted_buckets #(
  parameter int BUCKETS          = chtsb_pkg::BUCKETS_DEF,
  parameter int SLOTS_PER_BUCKET = chtsb_pkg::SLOTS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire chtsb_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output chtsb_pkg::out_item_t      out_data
);

  localparam int BW = $clog2(BUCKETS);
  localparam int FW = $clog2(SLOTS_PER_BUCKET + 1);
  localparam logic [BW-1:0] LAST_B = BW'(BUCKETS - 1);

  chtsb_pkg::state_e state_r;
  chtsb_pkg::state_e state_nxt;

  // bucket memories: fill count and sorted slot row
  logic [FW-1:0]                                        fill_mem [BUCKETS];
  logic [SLOTS_PER_BUCKET-1:0][chtsb_pkg::KEY_W-1:0]    slot_mem [BUCKETS];

  logic [FW-1:0]                                        fill_rd_r;
  logic [SLOTS_PER_BUCKET-1:0][chtsb_pkg::KEY_W-1:0]    slot_rd_r;
  logic [SLOTS_PER_BUCKET-1:0][chtsb_pkg::KEY_W-1:0]    slots_nxt;
  logic [FW-1:0]                                        fill_nxt;
  chtsb_pkg::row_res_t                                  res;

  logic [BW-1:0]        clr_cnt_r;
  logic [BW-1:0]        bkt_r;
  logic [BW-1:0]        hash_bkt;
  logic                 hash_done;
  logic                 hash_start;
  chtsb_pkg::mode_e     mode_r;
  chtsb_pkg::key_t      key_r;
  logic                 rd_en;
  logic                 upd_go;
  logic                 out_free;
  logic                 out_valid_r;
  chtsb_pkg::out_item_t out_data_r;

  chtsb_hash #(
    .BUCKETS (BUCKETS),
    .BW      (BW)
  ) u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (hash_start),
    .key    (in_data.key),
    .done   (hash_done),
    .bucket (hash_bkt)
  );

  chtsb_row_upd #(
    .SLOTS (SLOTS_PER_BUCKET),
    .FW    (FW)
  ) u_row (
    .mode      (mode_r),
    .key       (key_r),
    .fill      (fill_rd_r),
    .slots     (slot_rd_r),
    .slots_nxt (slots_nxt),
    .fill_nxt  (fill_nxt),
    .res       (res)
  );

  assign out_free = !out_valid_r || !out_stall;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    in_stall   = 1'b1;
    hash_start = 1'b0;
    rd_en      = 1'b0;
    upd_go     = 1'b0;
    unique case (state_r)
      chtsb_pkg::S_CLEAR: begin
        if (clr_cnt_r == LAST_B) begin
          state_nxt = chtsb_pkg::S_IDLE;
        end
      end
      chtsb_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          hash_start = 1'b1;
          state_nxt  = chtsb_pkg::S_HASH;
        end
      end
      chtsb_pkg::S_HASH: begin
        if (hash_done) begin
          rd_en     = 1'b1;
          state_nxt = chtsb_pkg::S_UPDATE;
        end
      end
      chtsb_pkg::S_UPDATE: begin
        if (out_free) begin
          upd_go    = 1'b1;
          state_nxt = chtsb_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = chtsb_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= chtsb_pkg::S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == chtsb_pkg::S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + BW'(1);
      end
    end
  end

  // capture the transaction
  always_ff @(posedge clk) begin
    if (hash_start) begin
      mode_r <= in_data.mode;
      key_r  <= in_data.key;
    end
    if (rd_en) begin
      bkt_r <= hash_bkt;
    end
  end

  // memory ports: one read, one write per cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      fill_rd_r <= fill_mem[hash_bkt];
      slot_rd_r <= slot_mem[hash_bkt];
    end
    if (state_r == chtsb_pkg::S_CLEAR) begin
      fill_mem[clr_cnt_r] <= '0;
    end else if (upd_go && res.wr) begin
      fill_mem[bkt_r] <= fill_nxt;
      slot_mem[bkt_r] <= slots_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      out_data_r.status <= res.status;
      out_data_r.bucket <= chtsb_pkg::bucket_t'(bkt_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

>>> verif/tb_chained_hash_table_sorted_buckets.sv
`timescale 1ns / 1ps

module tb_chained_hash_table_sorted_buckets;

  localparam int BUCKET_COUNT  = chtsb_pkg::BUCKETS_DEF;
  localparam int SLOT_COUNT    = chtsb_pkg::SLOTS_DEF;
  localparam int RANDOM_ITEMS  = 1750;
  localparam int SETTLE_CYCLES = 20;
  localparam logic [chtsb_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam chtsb_pkg::key_t KEY_MAX = '1;

  typedef struct {
    chtsb_pkg::in_item_t  item;
    bit                   typed;
    chtsb_pkg::out_item_t answer;
  } directed_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  chtsb_pkg::in_item_t  in_data;
  logic                 out_valid;
  logic                 out_stall;
  chtsb_pkg::out_item_t out_data;

  // shadow copy of the table
  int unsigned     table_fill [BUCKET_COUNT];
  chtsb_pkg::key_t table_keys [BUCKET_COUNT][SLOT_COUNT];

  chtsb_pkg::out_item_t expected_answers[$];
  directed_row_t        directed_rows[$];

  int  mismatch_count;
  int  op_count [4];
  int  op_ok    [4];
  int  full_count;
  bit  in_quiet;
  bit  out_quiet;

  chained_hash_table_sorted_buckets #(
    .BUCKETS          (BUCKET_COUNT),
    .SLOTS_PER_BUCKET (SLOT_COUNT)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("FAIL chained_hash_table_sorted_buckets");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // apply one operation to the shadow table and return its status
  function automatic chtsb_pkg::status_e hash_table_op(input chtsb_pkg::in_item_t req);
    int b;
    int n;
    int pos;
    int i;
    b = int'(req.key % BUCKET_COUNT);
    n = table_fill[b];
    case (req.mode)
      chtsb_pkg::MODE_INSERT: begin
        if (n >= SLOT_COUNT) return chtsb_pkg::ST_FULL;
        pos = 0;
        while (pos < n && table_keys[b][pos] < req.key) pos++;
        for (i = n; i > pos; i--) table_keys[b][i] = table_keys[b][i-1];
        table_keys[b][pos] = req.key;
        table_fill[b] = n + 1;
        return chtsb_pkg::ST_OK;
      end
      chtsb_pkg::MODE_SEARCH: begin
        for (i = 0; i < n; i++)
          if (table_keys[b][i] == req.key) return chtsb_pkg::ST_OK;
        return chtsb_pkg::ST_NOT_FOUND;
      end
      chtsb_pkg::MODE_DELETE: begin
        for (i = 0; i < n; i++) begin
          if (table_keys[b][i] == req.key) begin
            for (pos = i; pos + 1 < n; pos++) table_keys[b][pos] = table_keys[b][pos+1];
            table_fill[b] = n - 1;
            return chtsb_pkg::ST_OK;
          end
        end
        return chtsb_pkg::ST_NOT_FOUND;
      end
      default: return chtsb_pkg::ST_NOT_FOUND;
    endcase
  endfunction

  task automatic add_row(input logic [chtsb_pkg::MODE_W-1:0] m, input chtsb_pkg::key_t k,
                         input bit typed, input chtsb_pkg::status_e st,
                         input chtsb_pkg::bucket_t bk);
    directed_row_t row;
    row.item.mode     = chtsb_pkg::mode_e'(m);
    row.item.key      = k;
    row.typed         = typed;
    row.answer.status = st;
    row.answer.bucket = bk;
    directed_rows.push_back(row);
  endtask

  // drive one transaction; called at a falling edge, returns at a falling edge
  task automatic send_request(input chtsb_pkg::in_item_t req, input bit typed,
                              input chtsb_pkg::out_item_t typed_answer);
    int                   gap;
    chtsb_pkg::out_item_t ans;
    gap = in_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ans.status = hash_table_op(req);
    ans.bucket = chtsb_pkg::bucket_t'(req.key % BUCKET_COUNT);
    expected_answers.push_back(typed ? typed_answer : ans);
    op_count[req.mode]++;
    if (ans.status == chtsb_pkg::ST_OK) op_ok[req.mode]++;
    if (ans.status == chtsb_pkg::ST_FULL) full_count++;
    @(negedge clk);
  endtask

  // result side: random stall, then take one transaction and check it
  initial begin
    int                   stall_len;
    chtsb_pkg::out_item_t want;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall_len = out_quiet ? 0 : $urandom_range(0, 19);
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (expected_answers.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d bucket=%0d",
                                  out_data.status, out_data.bucket));
      end else begin
        want = expected_answers.pop_front();
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d (bucket %0d)",
                                    out_data.status, want.status, want.bucket));
        if (out_data.bucket !== want.bucket)
          report_mismatch($sformatf("bucket got %0d want %0d",
                                    out_data.bucket, want.bucket));
      end
      @(negedge clk);
    end
  end

  // stimulus
  initial begin
    chtsb_pkg::in_item_t req;
    logic [26:0]         key_hi;
    logic [3:0]          key_bucket;
    int                  pick;
    bit                  fill_heavy;
    int                  i;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    mismatch_count = 0;
    full_count     = 0;
    in_quiet       = 1'b0;
    out_quiet      = 1'b0;
    fill_heavy     = 1'b0;
    foreach (op_count[m]) begin
      op_count[m] = 0;
      op_ok[m]    = 0;
    end
    foreach (table_fill[b]) table_fill[b] = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty table, extremes, unused mode, a bucket filled to the brim
    add_row(chtsb_pkg::MODE_SEARCH, 31'd0, 1'b1, chtsb_pkg::ST_NOT_FOUND, 4'd0);
    add_row(chtsb_pkg::MODE_DELETE, KEY_MAX, 1'b1, chtsb_pkg::ST_NOT_FOUND, 4'd15);
    add_row(MODE_UNUSED, 31'd5, 1'b1, chtsb_pkg::ST_NOT_FOUND, 4'd5);
    add_row(chtsb_pkg::MODE_INSERT, KEY_MAX, 1'b1, chtsb_pkg::ST_OK, 4'd15);
    add_row(chtsb_pkg::MODE_INSERT, 31'd0, 1'b1, chtsb_pkg::ST_OK, 4'd0);
    add_row(chtsb_pkg::MODE_SEARCH, KEY_MAX, 1'b1, chtsb_pkg::ST_OK, 4'd15);
    add_row(chtsb_pkg::MODE_INSERT, 31'h7FFF_FFF3, 1'b1, chtsb_pkg::ST_OK, 4'd3);
    add_row(chtsb_pkg::MODE_INSERT, 31'd3, 1'b0, chtsb_pkg::ST_OK, 4'd0);
    add_row(chtsb_pkg::MODE_INSERT, 31'd19, 1'b0, chtsb_pkg::ST_OK, 4'd0);
    add_row(chtsb_pkg::MODE_INSERT, 31'd19, 1'b0, chtsb_pkg::ST_OK, 4'd0);
    add_row(chtsb_pkg::MODE_INSERT, 31'd35, 1'b0, chtsb_pkg::ST_OK, 4'd0);
    add_row(chtsb_pkg::MODE_INSERT, 31'd51, 1'b0, chtsb_pkg::ST_OK, 4'd0);
    add_row(chtsb_pkg::MODE_INSERT, 31'd67, 1'b0, chtsb_pkg::ST_OK, 4'd0);
    add_row(chtsb_pkg::MODE_INSERT, 31'd83, 1'b0, chtsb_pkg::ST_OK, 4'd0);
    add_row(chtsb_pkg::MODE_INSERT, 31'd99, 1'b0, chtsb_pkg::ST_OK, 4'd0);
    add_row(chtsb_pkg::MODE_DELETE, 31'd19, 1'b0, chtsb_pkg::ST_OK, 4'd0);
    add_row(chtsb_pkg::MODE_SEARCH, 31'd19, 1'b0, chtsb_pkg::ST_OK, 4'd0);
    add_row(chtsb_pkg::MODE_DELETE, 31'd19, 1'b0, chtsb_pkg::ST_OK, 4'd0);
    add_row(chtsb_pkg::MODE_SEARCH, 31'd19, 1'b0, chtsb_pkg::ST_OK, 4'd0);
    add_row(chtsb_pkg::MODE_DELETE, 31'h7FFF_FFF3, 1'b0, chtsb_pkg::ST_OK, 4'd0);
    add_row(chtsb_pkg::MODE_INSERT, 31'd99, 1'b0, chtsb_pkg::ST_OK, 4'd0);
    add_row(chtsb_pkg::MODE_DELETE, 31'd0, 1'b0, chtsb_pkg::ST_OK, 4'd0);
    add_row(MODE_UNUSED, KEY_MAX, 1'b1, chtsb_pkg::ST_NOT_FOUND, 4'd15);
    add_row(chtsb_pkg::MODE_INSERT, 31'h2AAA_AAAA, 1'b1, chtsb_pkg::ST_OK, 4'd10);
    add_row(chtsb_pkg::MODE_INSERT, 31'h5555_5555, 1'b1, chtsb_pkg::ST_OK, 4'd5);

    foreach (directed_rows[r])
      send_request(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].answer);

    // random: alternate filling and draining phases, keys mostly from a small pool
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) begin
        in_quiet  = ($urandom_range(0, 3) == 0);
        out_quiet = ($urandom_range(0, 3) == 0);
      end
      if (i % 150 == 0) fill_heavy = ~fill_heavy;
      pick = $urandom_range(0, 99);
      if (fill_heavy)
        req.mode = (pick < 55) ? chtsb_pkg::MODE_INSERT :
                   (pick < 75) ? chtsb_pkg::MODE_SEARCH :
                   (pick < 97) ? chtsb_pkg::MODE_DELETE : chtsb_pkg::mode_e'(MODE_UNUSED);
      else
        req.mode = (pick < 20) ? chtsb_pkg::MODE_INSERT :
                   (pick < 45) ? chtsb_pkg::MODE_SEARCH :
                   (pick < 95) ? chtsb_pkg::MODE_DELETE : chtsb_pkg::mode_e'(MODE_UNUSED);
      key_bucket = 4'($urandom_range(0, 15));
      key_hi     = ($urandom_range(0, 4) == 0) ? 27'($urandom) : 27'($urandom_range(0, 5));
      req.key    = {key_hi, key_bucket};
      send_request(req, 1'b0, '0);
    end
    in_valid <= 1'b0;

    // drain
    while (expected_answers.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d inserts (%0d refused as full), %0d searches (%0d found),",
             op_count[chtsb_pkg::MODE_INSERT], full_count,
             op_count[chtsb_pkg::MODE_SEARCH], op_ok[chtsb_pkg::MODE_SEARCH]);
    $display("  %0d deletes (%0d removed), %0d unused-mode; %0d mismatches",
             op_count[chtsb_pkg::MODE_DELETE], op_ok[chtsb_pkg::MODE_DELETE],
             op_count[MODE_UNUSED], mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS chained_hash_table_sorted_buckets");
    end else begin
      $display("FAIL chained_hash_table_sorted_buckets");
    end
    $finish;
  end

endmodule
